[hw/rtl/sraef_pkg.sv]
// Shared types and constants for the sparse row accumulator with eps filter.
// Holds stream field layout, controller state enum and the control/status bundles.
// No dependencies.
package sraef_pkg;

   // Column space and derived index widths
   localparam int NUM_COLS = 64;
   localparam int COL_BITS = $clog2(NUM_COLS);
   localparam int CNT_BITS = $clog2(NUM_COLS + 1);

   // Field widths
   localparam int ROW_W    = 16;
   localparam int COL_W    = 6;
   localparam int IN_VAL_W = 32;
   localparam int ACC_W    = 64;
   localparam int EPS_W    = 63;

   // Request tdata layout: row, col, a_value, b_value (lowest bit first)
   localparam int REQ_ROW_LSB = 0;
   localparam int REQ_COL_LSB = REQ_ROW_LSB + ROW_W;
   localparam int REQ_A_LSB   = REQ_COL_LSB + COL_W;
   localparam int REQ_B_LSB   = REQ_A_LSB + IN_VAL_W;
   localparam int REQ_TDATA_W = ((REQ_B_LSB + IN_VAL_W + 7) / 8) * 8;

   // Response tdata layout: out_row, out_col, out_value (lowest bit first)
   localparam int RSP_ROW_LSB = 0;
   localparam int RSP_COL_LSB = RSP_ROW_LSB + ROW_W;
   localparam int RSP_VAL_LSB = RSP_COL_LSB + COL_W;
   localparam int RSP_TDATA_W = ((RSP_VAL_LSB + ACC_W + 7) / 8) * 8;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LIST,
      ST_ACC,
      ST_EVAL,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic ready;      // request channel open
      logic take;       // request transfer this cycle
      logic update;     // accumulator read-modify-write
      logic list_rd;    // read touched list at drain index
      logic acc_rd;     // read accumulator of listed column, clear its mark
      logic eval_step;  // judge current column and advance drain index
      logic finish;     // emit closing result and reset row state
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic in_prod;    // offered item carries a usable product
      logic in_eor;     // offered item closes the row
      logic eor;        // captured item closes the row
      logic keep;       // current drain column passes the filter
      logic hold_valid; // a kept entry is waiting in the hold stage
      logic out_free;   // result register can take a new entry
      logic idx_last;   // drain index is at the last touched column
      logic count_zero; // no column touched in this row
   } status_type;

endpackage

[hw/rtl/sparse_row_accumulator_eps_filter.sv]
// Row-wise sparse accumulator for a Gustavson product with an eps drop filter. For an item
// with a product the transfer cycle multiplies and reads the column's accumulator RAM, and
// the next cycle does the saturating add and writes it back. An item with neither product
// nor row end leaves the controller idle. A row end then walks the touched columns in
// first-touch order (list RAM read, accumulator RAM read, filter) and closes the row,
// waiting while the result register is not taken; no request is taken during that walk.
// Occupied marks reset at once, so no clearing pass follows reset. Depends on sraef_pkg,
// sraef_ctrl, sraef_dpath and sraef_ram.
module sparse_row_accumulator_eps_filter import sraef_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // row[15:0], col[21:16], a_value[53:22],
                                              // b_value[85:54], zero pad
   input  logic                   req_tuser,  // has_product
   input  logic                   req_tlast,  // end_of_row
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_row[15:0], out_col[21:16],
                                              // out_value[85:22], zero pad
   output logic                   rsp_tuser,  // entry_valid
   output logic                   rsp_tlast,  // last_in_row
   // eps register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [EPS_W-1:0]       csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign req_tready = cmd.ready;

   sraef_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   sraef_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef ASSERT_OFF
   // An empty-row marker always closes its row
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("empty-row marker without last_in_row");

   // Controller issues at most one operation per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.update, cmd.list_rd, cmd.acc_rd, cmd.eval_step, cmd.finish}))
      else $error("overlapping datapath commands");

   // Never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || (cmd.eval_step && status.keep && status.hold_valid)) |-> status.out_free)
      else $error("result register overwritten");

   // A product transfer is followed by its update cycle, with the request side closed
   a_update_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && status.in_prod) |=> (cmd.update && !req_tready))
      else $error("missing accumulator update after product transfer");
`endif

endmodule

[hw/rtl/sraef_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sraef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_data_in;

   // Hold read data unless a read is issued
   always_comb begin
      rd_data_in = rd_data_ff;
      if (rd_en) begin
         rd_data_in = mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sraef_ctrl.sv]
// Controller of the sparse row accumulator: sequences accept, update and drain.
// Depends on sraef_pkg.
module sraef_ctrl import sraef_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               priority if (status.in_prod) begin
                  state_in = ST_UPDATE;
               end else if (status.in_eor) begin
                  state_in = status.count_zero ? ST_FINISH : ST_LIST;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_UPDATE: begin
            state_in = status.eor ? ST_LIST : ST_IDLE;
         end
         ST_LIST: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!(status.keep && status.hold_valid && !status.out_free)) begin
               state_in = status.idx_last ? ST_FINISH : ST_LIST;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            cmd.take  = req_tvalid;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_LIST: begin
            cmd.list_rd = 1'b1;
         end
         ST_ACC: begin
            cmd.acc_rd = 1'b1;
         end
         ST_EVAL: begin
            // stall while a kept entry must leave the hold stage but the output is busy
            cmd.eval_step = !(status.keep && status.hold_valid && !status.out_free);
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/sraef_dpath.sv]
// Datapath of the sparse row accumulator: product register, accumulator and touched-list RAMs,
// occupied marks, eps filter, hold stage and result register.
// Depends on sraef_pkg and sraef_ram.
module sraef_dpath import sraef_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [EPS_W-1:0]       csr_wdata,
   input  cmd_type                cmd,
   output status_type             status
);

   // Saturating signed add
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W-1:0] s;
      s = a + b;
      if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
         s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s;
   endfunction

   // Request fields
   logic [ROW_W-1:0]           req_row;
   logic [COL_W-1:0]           req_col;
   logic signed [IN_VAL_W-1:0] req_a;
   logic signed [IN_VAL_W-1:0] req_b;
   logic signed [ACC_W-1:0]    req_prod;

   assign req_row  = req_tdata[REQ_ROW_LSB +: ROW_W];
   assign req_col  = req_tdata[REQ_COL_LSB +: COL_W];
   assign req_a    = req_tdata[REQ_A_LSB +: IN_VAL_W];
   assign req_b    = req_tdata[REQ_B_LSB +: IN_VAL_W];
   assign req_prod = req_a * req_b;

   // Registers
   logic [EPS_W-1:0]    eps_ff, eps_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ACC_W-1:0]    prod_ff, prod_in;
   logic                eor_ff, eor_in;
   logic [NUM_COLS-1:0] occupied_ff, occupied_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [COL_BITS-1:0] drain_col_ff, drain_col_in;
   logic                hold_valid_ff, hold_valid_in;
   logic [COL_BITS-1:0] hold_col_ff, hold_col_in;
   logic [ACC_W-1:0]    hold_val_ff, hold_val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_BITS-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [ACC_W-1:0]    rsp_val_ff, rsp_val_in;
   logic                rsp_entry_ff, rsp_entry_in;
   logic                rsp_last_ff, rsp_last_in;

   // RAM ports
   logic [COL_BITS-1:0] acc_rd_addr;
   logic [ACC_W-1:0]    acc_rd_data;
   logic [ACC_W-1:0]    acc_sum;
   logic                acc_rd_en;
   logic                list_wr_en;
   logic [COL_BITS-1:0] list_rd_data;
   logic                occ_hit;

   // Filter and output control
   logic [ACC_W-1:0]    magnitude;
   logic                keep;
   logic                push_hold;
   logic                push_marker;
   logic                out_free;

   assign occ_hit     = occupied_ff[col_ff];
   assign acc_sum     = occ_hit ? sat_add(acc_rd_data, prod_ff) : prod_ff;
   assign acc_rd_en   = cmd.take | cmd.acc_rd;
   assign acc_rd_addr = cmd.take ? req_col[COL_BITS-1:0] : list_rd_data;
   assign list_wr_en  = cmd.update & ~occ_hit;

   sraef_ram #(
      .WIDTH (ACC_W),
      .DEPTH (NUM_COLS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (col_ff),
      .wr_data (acc_sum),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   sraef_ram #(
      .WIDTH (COL_BITS),
      .DEPTH (NUM_COLS)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (count_ff[COL_BITS-1:0]),
      .wr_data (col_ff),
      .rd_en   (cmd.list_rd),
      .rd_addr (idx_ff[COL_BITS-1:0]),
      .rd_data (list_rd_data)
   );

   // Keep a column on the diagonal or above the threshold
   assign magnitude = acc_rd_data[ACC_W-1] ? (~acc_rd_data + 1'b1) : acc_rd_data;
   assign keep      = (ROW_W'(drain_col_ff) == row_ff) || (magnitude > {1'b0, eps_ff});

   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign push_hold   = (cmd.eval_step & keep & hold_valid_ff) | (cmd.finish & hold_valid_ff);
   assign push_marker = cmd.finish & ~hold_valid_ff;

   // Capture request, write eps
   always_comb begin
      eps_in  = eps_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      prod_in = prod_ff;
      eor_in  = eor_ff;
      if (csr_valid && csr_ready) begin
         eps_in = csr_wdata;
      end
      if (cmd.take) begin
         row_in  = req_row;
         col_in  = req_col[COL_BITS-1:0];
         prod_in = req_prod;
         eor_in  = req_tlast;
      end
   end

   // Marks, list fill and drain walk
   always_comb begin
      occupied_in  = occupied_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      drain_col_in = drain_col_ff;
      if (list_wr_en) begin
         occupied_in[col_ff] = 1'b1;
         count_in            = count_ff + 1'b1;
      end
      if (cmd.acc_rd) begin
         occupied_in[list_rd_data] = 1'b0;
         drain_col_in              = list_rd_data;
      end
      if (cmd.eval_step) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.finish) begin
         count_in = '0;
         idx_in   = '0;
      end
   end

   // Hold stage: the latest kept entry waits until it is known whether it is last
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_col_in   = hold_col_ff;
      hold_val_in   = hold_val_ff;
      if (cmd.eval_step && keep) begin
         hold_valid_in = 1'b1;
         hold_col_in   = drain_col_ff;
         hold_val_in   = acc_rd_data;
      end
      if (cmd.finish) begin
         hold_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      if (push_hold || push_marker) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = row_ff;
         rsp_col_in   = push_marker ? '0 : hold_col_ff;
         rsp_val_in   = push_marker ? '0 : hold_val_ff;
         rsp_entry_in = ~push_marker;
         rsp_last_in  = cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff        <= '0;
         occupied_ff   <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         eps_ff        <= eps_in;
         occupied_ff   <= occupied_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      prod_ff      <= prod_in;
      eor_ff       <= eor_in;
      drain_col_ff <= drain_col_in;
      hold_col_ff  <= hold_col_in;
      hold_val_ff  <= hold_val_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Ports
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_val_ff, COL_W'(rsp_col_ff), rsp_row_ff});
   assign rsp_tuser  = rsp_entry_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Status
   always_comb begin
      status            = '0;
      status.in_prod    = req_tuser & ({1'b0, req_col} < (COL_W + 1)'(NUM_COLS));
      status.in_eor     = req_tlast;
      status.eor        = eor_ff;
      status.keep       = keep;
      status.hold_valid = hold_valid_ff;
      status.out_free   = out_free;
      status.idx_last   = (CNT_BITS'(idx_ff + 1'b1) == count_ff);
      status.count_zero = (count_ff == '0);
   end

endmodule
